// ===== hw/rtl/npa_pkg.sv =====
package npa_pkg;

    localparam int POOL_NODES = 1024;
    localparam int NODE_W     = 10;
    localparam int STATUS_W   = 3;
    localparam int WORD_W     = 64;
    localparam int OFF_W      = $clog2(WORD_W);
    localparam int NUM_WORDS  = POOL_NODES / WORD_W;
    localparam int ADDR_W     = $clog2(NUM_WORDS);

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [OFF_W-1:0]  off_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_RESERVED = 3'd1,
        ST_ABOVE    = 3'd2,
        ST_DOUBLE   = 3'd3,
        ST_OOM      = 3'd4
    } status_t;

    localparam node_t LAST_NODE_RESET = node_t'(1023);
    localparam node_t LIMIT_MAX       = node_t'(POOL_NODES - 1);
    localparam node_t HW_RESET        = node_t'(1);

    // free map port request
    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        word_t wr_data;
    } map_req_t;

    // bit scan result
    typedef struct packed {
        logic found;
        off_t pos;
    } scan_res_t;

    function automatic addr_t word_of(input node_t n);
        return addr_t'(n >> OFF_W);
    endfunction

    function automatic off_t off_of(input node_t n);
        return n[OFF_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/npa_if.sv =====
interface npa_req_if
    import npa_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  operation;
    node_t node_index;

    modport source (output valid, output operation, output node_index, input ready);
    modport sink   (input valid, input operation, input node_index, output ready);
endinterface

interface npa_resp_if
    import npa_pkg::*;
();
    logic                valid;
    logic                ready;
    node_t               granted_node;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_node, output status, input ready);
    modport sink   (input valid, input granted_node, input status, output ready);
endinterface

interface npa_cfg_if
    import npa_pkg::*;
();
    logic  valid;
    logic  ready;
    node_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/npa_bit_scan.sv =====
// Shared 64-bit priority scan: lowest set bit, or highest when find_high.
module npa_bit_scan
    import npa_pkg::*;
(
    input  word_t     scan_word,
    input  logic      find_high,
    output scan_res_t result
);

    word_t vec;
    off_t  low_pos;
    logic  any;

    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            vec[i] = find_high ? scan_word[WORD_W-1-i] : scan_word[i];
        end
    end

    always_comb
    begin
        any     = 1'b0;
        low_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                any     = 1'b1;
                low_pos = off_t'(i);
            end
        end
    end

    assign result.found = any;
    assign result.pos   = find_high ? off_t'(WORD_W - 1) - low_pos : low_pos;

endmodule

// ===== hw/rtl/npa_free_map.sv =====
// Free map: NUM_WORDS x WORD_W bits, one write and one registered read a cycle.
// Per-row valid bits make a never-written row read as all clear.
module npa_free_map
    import npa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  map_req_t req,
    output word_t    rd_data
);

    word_t                 mem [NUM_WORDS];
    logic [NUM_WORDS-1:0]  row_valid_reg;
    word_t                 rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            row_valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= row_valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/node_pool_allocator.sv =====
// Channel | Dir | Payload                         | Accepted when
// req     | in  | operation, node_index           | req.valid && req.ready
// resp    | out | granted_node, status            | resp.valid && resp.ready
// cfg     | in  | data (last_node)                | cfg.valid && cfg.ready (always ready)
//
// Allocate: words are read up from word 0 to where the scan stops (lowest word with a free
// node, else the mark's word), one 64-bit map word a cycle into a shared scan. Free: reserved
// or above the mark goes to FINISH; a node to mark or a double free ends in FREE_CHECK;
// SHRINK walks words down to lower the mark. One item at a time; req.ready low meanwhile.
// Reset clears the mark to 1, last_node to 1023 and the free map via per-word valid bits.
// The result register lets the next item start while a result waits; FINISH then holds.
module node_pool_allocator
    import npa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    npa_req_if.sink      req,
    npa_resp_if.source   resp,
    npa_cfg_if.sink      cfg
);

    typedef enum logic [2:0] {
        IDLE,
        ALLOC_SCAN,
        FREE_CHECK,
        SHRINK,
        FINISH
    } state_t;

    state_t  state_reg, state_next;
    node_t   hw_reg, hw_next;                 // high-water mark
    node_t   last_node_reg, last_node_next;
    node_t   node_reg, node_next;             // node being freed
    addr_t   ptr_reg, ptr_next;               // word whose data is on rd_data
    off_t    off_reg, off_next;               // top bit still in play while shrinking
    node_t   res_node_reg, res_node_next;
    status_t res_status_reg, res_status_next;
    logic    resp_valid_reg, resp_valid_next;
    node_t   resp_node_reg, resp_node_next;
    status_t resp_status_reg, resp_status_next;

    map_req_t  map_req;
    word_t     rd_data;
    word_t     scan_word;
    logic      find_high;
    scan_res_t scan;

    node_t limit;
    word_t mask_off;    // bits 0..off_reg
    word_t mask_pos;    // bits 0..scan.pos
    off_t  bit_off;

    npa_free_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .rd_data (rd_data)
    );

    npa_bit_scan u_scan (
        .scan_word (scan_word),
        .find_high (find_high),
        .result    (scan)
    );

    assign limit    = (last_node_reg > LIMIT_MAX) ? LIMIT_MAX : last_node_reg;
    assign mask_off = word_t'('1) >> (off_t'(WORD_W - 1) - off_reg);
    assign mask_pos = word_t'('1) >> (off_t'(WORD_W - 1) - scan.pos);
    assign bit_off  = off_of(node_reg);

    // shared scan: lowest free bit on allocate, highest in-use bit when shrinking
    always_comb
    begin
        find_high = (state_reg == SHRINK);
        scan_word = (state_reg == SHRINK) ? (~rd_data & mask_off) : rd_data;
    end

    always_comb
    begin
        state_next       = state_reg;
        hw_next          = hw_reg;
        last_node_next   = last_node_reg;
        node_next        = node_reg;
        ptr_next         = ptr_reg;
        off_next         = off_reg;
        res_node_next    = res_node_reg;
        res_status_next  = res_status_reg;
        resp_valid_next  = resp_valid_reg;
        resp_node_next   = resp_node_reg;
        resp_status_next = resp_status_reg;
        map_req          = '0;

        if (cfg.valid)
        begin
            last_node_next = cfg.data;
        end

        if (resp_valid_reg && resp.ready)
        begin
            resp_valid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (req.valid)
                begin
                    node_next     = req.node_index;
                    res_node_next = '0;
                    if (req.operation == OP_ALLOC)
                    begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = '0;
                        ptr_next        = '0;
                        state_next      = ALLOC_SCAN;
                    end
                    else if (req.node_index <= node_t'(1))
                    begin
                        res_status_next = ST_RESERVED;
                        state_next      = FINISH;
                    end
                    else if (req.node_index > hw_reg)
                    begin
                        res_status_next = ST_ABOVE;
                        state_next      = FINISH;
                    end
                    else
                    begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = word_of(req.node_index);
                        state_next      = FREE_CHECK;
                    end
                end
            end

            ALLOC_SCAN:
            begin
                // free bits only exist below the mark, so the scan stops at its word
                if (scan.found)
                begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = ptr_reg;
                    map_req.wr_data = rd_data & ~(word_t'(1) << scan.pos);
                    res_node_next   = {ptr_reg, scan.pos};
                    res_status_next = ST_OK;
                    state_next      = FINISH;
                end
                else if (ptr_reg == word_of(hw_reg))
                begin
                    if (hw_reg >= limit)
                    begin
                        res_node_next   = '0;
                        res_status_next = ST_OOM;
                    end
                    else
                    begin
                        hw_next         = hw_reg + node_t'(1);
                        res_node_next   = hw_reg + node_t'(1);
                        res_status_next = ST_OK;
                    end
                    state_next = FINISH;
                end
                else
                begin
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = ptr_reg + addr_t'(1);
                    ptr_next        = ptr_reg + addr_t'(1);
                end
            end

            FREE_CHECK:
            begin
                if (rd_data[bit_off])
                begin
                    res_status_next = ST_DOUBLE;
                    state_next      = FINISH;
                end
                else if (node_reg == hw_reg)
                begin
                    // walk down from the node below the mark
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = word_of(node_reg - node_t'(1));
                    ptr_next        = word_of(node_reg - node_t'(1));
                    off_next        = off_of(node_reg - node_t'(1));
                    state_next      = SHRINK;
                end
                else
                begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = word_of(node_reg);
                    map_req.wr_data = rd_data | (word_t'(1) << bit_off);
                    res_status_next = ST_OK;
                    state_next      = FINISH;
                end
            end

            SHRINK:
            begin
                // nodes 0 and 1 are never free, so word 0 always ends the walk
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = ptr_reg;
                if (scan.found)
                begin
                    map_req.wr_data = rd_data & (~mask_off | mask_pos);
                    hw_next         = {ptr_reg, scan.pos};
                    res_status_next = ST_OK;
                    state_next      = FINISH;
                end
                else
                begin
                    map_req.wr_data = rd_data & ~mask_off;
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = ptr_reg - addr_t'(1);
                    ptr_next        = ptr_reg - addr_t'(1);
                    off_next        = off_t'(WORD_W - 1);
                end
            end

            FINISH:
            begin
                if (!resp_valid_reg || resp.ready)
                begin
                    resp_valid_next  = 1'b1;
                    resp_node_next   = res_node_reg;
                    resp_status_next = res_status_reg;
                    state_next       = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            hw_reg          <= HW_RESET;
            last_node_reg   <= LAST_NODE_RESET;
            node_reg        <= '0;
            ptr_reg         <= '0;
            off_reg         <= '0;
            res_node_reg    <= '0;
            res_status_reg  <= ST_OK;
            resp_valid_reg  <= 1'b0;
            resp_node_reg   <= '0;
            resp_status_reg <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            hw_reg          <= hw_next;
            last_node_reg   <= last_node_next;
            node_reg        <= node_next;
            ptr_reg         <= ptr_next;
            off_reg         <= off_next;
            res_node_reg    <= res_node_next;
            res_status_reg  <= res_status_next;
            resp_valid_reg  <= resp_valid_next;
            resp_node_reg   <= resp_node_next;
            resp_status_reg <= resp_status_next;
        end
    end

    assign req.ready         = (state_reg == IDLE);
    assign cfg.ready         = 1'b1;
    assign resp.valid        = resp_valid_reg;
    assign resp.granted_node = resp_node_reg;
    assign resp.status       = resp_status_reg;

endmodule

// ===== hw/rtl/npa_checker.sv =====
module npa_checker
    import npa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                resp_valid,
    input logic                resp_ready,
    input node_t               granted_node,
    input logic [STATUS_W-1:0] status
);

    // one request in flight: busy right after taking a request
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> status <= STATUS_W'(ST_OOM))
        else $error("undefined status code");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && granted_node != '0 |-> status == STATUS_W'(ST_OK) &&
            granted_node >= node_t'(2))
        else $error("reserved node granted or grant with error");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && status != STATUS_W'(ST_OK) |-> granted_node == '0)
        else $error("failed request carries a node");

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(granted_node) && $stable(status))
        else $error("stalled response changed");

endmodule

bind node_pool_allocator npa_checker u_npa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .resp_valid   (resp.valid),
    .resp_ready   (resp.ready),
    .granted_node (resp.granted_node),
    .status       (resp.status)
);
